>>> hdl/psc_pkg.sv
// Shared widths, register codes and types of the pressure sensor compensation block.
package psc_pkg;

	// Field widths at the ports.
	localparam int RAW_W      = 24;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_W     = 19;
	localparam int OUT_W      = 32;

	// Internal widths, sized from the value ranges of the compensation math.
	localparam int DT_W       = 25;  // D2 - C5*256
	localparam int MUL_W      = 42;  // dT times a calibration word
	localparam int SQ_W       = 50;  // dT squared
	localparam int SQ11_W     = 54;  // 11 * dT squared
	localparam int TSQ_W      = 40;  // square of a 20-bit temperature offset
	localparam int ACC_W      = 44;  // OFF, SENS and their second-order forms
	localparam int LO_W       = 22;  // low slice of SENS2 for the split multiply
	localparam int HI_W       = ACC_W - LO_W;
	localparam int PPL_W      = RAW_W + LO_W;
	localparam int PPH_W      = RAW_W + 1 + HI_W;
	localparam int PROD_W     = 64;
	localparam int DIFF_W     = 45;
	localparam int PRESS_W    = DIFF_W - 15;
	localparam int DPROD_W    = 46;

	localparam int NUM_STAGES = 9;

	// Compensation constants.
	localparam int T_REF      = 2000;
	localparam int T_VERY_LOW = -1500;
	localparam int P_ATM      = 101325;
	localparam int DEPTH_GAIN = 6703;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFFSET_BASE = 3'd1,
		REG_SENS_TEMP   = 3'd2,
		REG_OFFSET_TEMP = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5
	} psc_reg_idx_t;

	// Calibration words C1..C6.
	typedef struct packed {
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] c3;
		logic [COEF_W-1:0] c4;
		logic [COEF_W-1:0] c5;
		logic [COEF_W-1:0] c6;
	} psc_coeff_t;

	// First-order results handed to the second-order stages.
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [ACC_W-1:0]  off;
		logic signed [ACC_W-1:0]  sens;
		logic signed [TEMP_W-1:0] ti;
	} psc_first_t;

	// Second-order corrected values handed to the pressure stages.
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp2;
		logic signed [ACC_W-1:0]  off2;
		logic signed [ACC_W-1:0]  sens2;
	} psc_second_t;

endpackage

>>> hdl/psc_if.sv
// Handshake channel interfaces: raw readings, compensated results and configuration writes.
interface psc_in_if;
	import psc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] pressure_raw;
	logic [RAW_W-1:0] temperature_raw;
	modport source (output valid, output pressure_raw, output temperature_raw, input ready);
	modport sink (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface psc_out_if;
	import psc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centideg;
	logic signed [OUT_W-1:0]  pressure_centimbar;
	logic signed [OUT_W-1:0]  depth_mm;
	modport source (output valid, output temperature_centideg, output pressure_centimbar,
		output depth_mm, input ready);
	modport sink (input valid, input temperature_centideg, input pressure_centimbar,
		input depth_mm, output ready);
endinterface

interface psc_cfg_if;
	import psc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/psc_ctrl.sv
// Pipeline control: per-stage valid bits and load enables that close bubbles under backpressure.
module psc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [psc_pkg::NUM_STAGES-1:0]   load
);
	import psc_pkg::*;

	logic [NUM_STAGES-1:0] stage_vld_q;

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		load[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			load[k] = !stage_vld_q[k] || load[k+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (load[0]) begin
				stage_vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = stage_vld_q[NUM_STAGES-1];

endmodule

>>> hdl/psc_first_order.sv
// Stages 1 to 3: temperature difference, calibration products and first-order TEMP, OFF, SENS.
module psc_first_order (
	input  logic                        clk,
	input  logic [2:0]                  load,
	input  psc_pkg::psc_coeff_t         coeff,
	input  logic [psc_pkg::RAW_W-1:0]   pressure_raw,
	input  logic [psc_pkg::RAW_W-1:0]   temperature_raw,
	output psc_pkg::psc_first_t         first
);
	import psc_pkg::*;

	logic [RAW_W-1:0]         d1_s1;
	logic signed [DT_W-1:0]   dt_s1;
	logic [RAW_W-1:0]         d1_s2;
	logic signed [MUL_W-1:0]  p6_s2;
	logic signed [MUL_W-1:0]  p4_s2;
	logic signed [MUL_W-1:0]  p3_s2;
	logic signed [SQ_W-1:0]   dtsq_s2;
	psc_first_t               first_s3;

	logic signed [DT_W-1:0]   dt_w;
	logic signed [MUL_W-1:0]  p6_bias_w;
	logic signed [TEMP_W-1:0] temp_w;
	logic signed [ACC_W-1:0]  off_base_w;
	logic signed [ACC_W-1:0]  sens_base_w;
	logic signed [SQ11_W-1:0] sq11_w;

	// Stage 1: dT = D2 - C5*256 (always fits in 25 signed bits).
	assign dt_w = $signed({1'b0, temperature_raw}) - $signed({1'b0, coeff.c5, 8'b0});

	always_ff @(posedge clk) begin
		if (load[0]) begin
			d1_s1 <= pressure_raw;
			dt_s1 <= dt_w;
		end
	end

	// Stage 2: the four products of dT.
	always_ff @(posedge clk) begin
		if (load[1]) begin
			d1_s2   <= d1_s1;
			p6_s2   <= dt_s1 * $signed({1'b0, coeff.c6});
			p4_s2   <= dt_s1 * $signed({1'b0, coeff.c4});
			p3_s2   <= dt_s1 * $signed({1'b0, coeff.c3});
			dtsq_s2 <= dt_s1 * dt_s1;
		end
	end

	// Stage 3: TEMP with a division by 2^23 that truncates toward zero, OFF, SENS and Ti.
	always_comb begin
		p6_bias_w   = p6_s2 + (p6_s2[MUL_W-1] ? MUL_W'((1 << 23) - 1) : '0);
		temp_w      = TEMP_W'(T_REF) + TEMP_W'(p6_bias_w >>> 23);
		off_base_w  = $signed({{(ACC_W-COEF_W-17){1'b0}}, coeff.c2, 17'b0});
		sens_base_w = $signed({{(ACC_W-COEF_W-16){1'b0}}, coeff.c1, 16'b0});
		sq11_w      = (SQ11_W'(dtsq_s2) <<< 3) + (SQ11_W'(dtsq_s2) <<< 1) + SQ11_W'(dtsq_s2);
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			first_s3.d1   <= d1_s2;
			first_s3.temp <= temp_w;
			first_s3.off  <= off_base_w + ACC_W'(p4_s2 >>> 6);
			first_s3.sens <= sens_base_w + ACC_W'(p3_s2 >>> 7);
			first_s3.ti   <= TEMP_W'(sq11_w >>> 35);
		end
	end

	assign first = first_s3;

endmodule

>>> hdl/psc_second_order.sv
// Stages 4 and 5: low and very-low temperature corrections of TEMP, OFF and SENS.
module psc_second_order (
	input  logic                  clk,
	input  logic [1:0]            load,
	input  psc_pkg::psc_first_t   first,
	output psc_pkg::psc_second_t  second
);
	import psc_pkg::*;

	psc_first_t               first_s4;
	logic                     low_s4;
	logic                     vlow_s4;
	logic signed [TSQ_W-1:0]  tsq_s4;
	logic signed [TSQ_W-1:0]  usq_s4;
	psc_second_t              second_s5;

	logic signed [TEMP_W:0]   t_w;
	logic signed [TEMP_W:0]   u_w;
	logic signed [ACC_W-1:0]  tsq_x;
	logic signed [ACC_W-1:0]  usq_x;
	logic signed [ACC_W-1:0]  offi_w;
	logic signed [ACC_W-1:0]  sensi_w;

	// Stage 4: squared distances from 20.00 degC and from -15.00 degC.
	assign t_w = (TEMP_W+1)'(first.temp) - (TEMP_W+1)'(T_REF);
	assign u_w = (TEMP_W+1)'(first.temp) - (TEMP_W+1)'(T_VERY_LOW);

	always_ff @(posedge clk) begin
		if (load[0]) begin
			first_s4 <= first;
			low_s4   <= first.temp < TEMP_W'(T_REF);
			vlow_s4  <= first.temp < TEMP_W'(T_VERY_LOW);
			tsq_s4   <= t_w * t_w;
			usq_s4   <= u_w * u_w;
		end
	end

	// Stage 5: OFFi = 31*t^2/8 (+17*u^2), SENSi = 63*t^2/32 (+9*u^2), all zero at or above 20 degC.
	always_comb begin
		tsq_x   = ACC_W'(tsq_s4);
		usq_x   = ACC_W'(usq_s4);
		offi_w  = ((tsq_x <<< 5) - tsq_x) >>> 3;
		sensi_w = ((tsq_x <<< 6) - tsq_x) >>> 5;
		if (vlow_s4) begin
			offi_w  = offi_w + (usq_x <<< 4) + usq_x;
			sensi_w = sensi_w + (usq_x <<< 3) + usq_x;
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			second_s5.d1    <= first_s4.d1;
			second_s5.temp2 <= low_s4 ? first_s4.temp - first_s4.ti : first_s4.temp;
			second_s5.off2  <= low_s4 ? first_s4.off - offi_w : first_s4.off;
			second_s5.sens2 <= low_s4 ? first_s4.sens - sensi_w : first_s4.sens;
		end
	end

	assign second = second_s5;

endmodule

>>> hdl/psc_pressure.sv
// Stages 6 to 9: split D1*SENS2 multiply, pressure, and depth scaling.
module psc_pressure (
	input  logic                              clk,
	input  logic [3:0]                        load,
	input  psc_pkg::psc_second_t              second,
	output logic signed [psc_pkg::TEMP_W-1:0] temperature_centideg,
	output logic signed [psc_pkg::OUT_W-1:0]  pressure_centimbar,
	output logic signed [psc_pkg::OUT_W-1:0]  depth_mm
);
	import psc_pkg::*;

	logic signed [TEMP_W-1:0]  temp2_s6;
	logic signed [ACC_W-1:0]   off2_s6;
	logic [PPL_W-1:0]          pp_lo_s6;
	logic signed [PPH_W-1:0]   pp_hi_s6;
	logic signed [TEMP_W-1:0]  temp2_s7;
	logic signed [ACC_W-1:0]   off2_s7;
	logic signed [PROD_W-1:0]  prod_s7;
	logic signed [TEMP_W-1:0]  temp2_s8;
	logic signed [PRESS_W-1:0] press_s8;
	logic signed [TEMP_W-1:0]  temp2_s9;
	logic signed [PRESS_W-1:0] press_s9;
	logic signed [DPROD_W-1:0] dprod_s9;

	logic signed [PROD_W-1:0]  prod_hi_w;
	logic signed [PROD_W-1:0]  prod_lo_w;
	logic signed [DIFF_W-1:0]  diff_w;
	logic signed [PRESS_W:0]   pdelta_w;

	// Stage 6: D1 times the low and high slices of SENS2.
	always_ff @(posedge clk) begin
		if (load[0]) begin
			temp2_s6 <= second.temp2;
			off2_s6  <= second.off2;
			pp_lo_s6 <= PPL_W'(second.d1) * PPL_W'(second.sens2[LO_W-1:0]);
			pp_hi_s6 <= $signed({1'b0, second.d1}) * $signed(second.sens2[ACC_W-1:LO_W]);
		end
	end

	// Stage 7: recombine the partial products into the full D1*SENS2.
	assign prod_hi_w = PROD_W'(pp_hi_s6) <<< LO_W;
	assign prod_lo_w = $signed(PROD_W'(pp_lo_s6));

	always_ff @(posedge clk) begin
		if (load[1]) begin
			temp2_s7 <= temp2_s6;
			off2_s7  <= off2_s6;
			prod_s7  <= prod_hi_w + prod_lo_w;
		end
	end

	// Stage 8: P = ((D1*SENS2 >> 21) - OFF2) >> 15; its range stays inside 30 bits.
	assign diff_w = DIFF_W'(prod_s7 >>> 21) - DIFF_W'(off2_s7);

	always_ff @(posedge clk) begin
		if (load[2]) begin
			temp2_s8 <= temp2_s7;
			press_s8 <= PRESS_W'(diff_w >>> 15);
		end
	end

	// Stage 9: depth product (P - 1013.25 mbar) * gain.
	assign pdelta_w = (PRESS_W+1)'(press_s8) - (PRESS_W+1)'(P_ATM);

	always_ff @(posedge clk) begin
		if (load[3]) begin
			temp2_s9 <= temp2_s8;
			press_s9 <= press_s8;
			dprod_s9 <= pdelta_w * $signed(15'(DEPTH_GAIN));
		end
	end

	// Both pressure and depth lie well inside 32 bits, so the clamp reduces to sign extension.
	assign temperature_centideg = temp2_s9;
	assign pressure_centimbar   = OUT_W'(press_s9);
	assign depth_mm             = OUT_W'(dprod_s9 >>> 16);

endmodule

>>> hdl/pressure_sensor_compensation_top.sv
// Top level of the pressure sensor compensation block: calibration registers and pipeline.
//
//   Channel   Dir   Beat contents
//   sample    in    pressure_raw, temperature_raw (D1, D2)
//   result    out   temperature_centideg, pressure_centimbar, depth_mm
//   cfg       in    index, data (calibration word C1..C6 at index 0..5)
//
// A reading pair's result is valid once it has passed the nine pipeline stages after its sample
// beat is taken; one pair can enter every cycle while sample is ready.
// Reset clears the stage valid bits and all six calibration words to zero.
// A stall on result holds the last stage; earlier stages keep loading until they fill, so
// empty slots close up and sample stays ready while any stage is free.
// Configuration writes are always taken; writes to an index past the last register are dropped.
module pressure_sensor_compensation_top (
	input  logic       clk,
	input  logic       arst_n,
	psc_cfg_if.sink    cfg,
	psc_in_if.sink     sample,
	psc_out_if.source  result
);
	import psc_pkg::*;

	psc_coeff_t            coeff_q;
	logic [NUM_STAGES-1:0] load;
	psc_first_t            first;
	psc_second_t           second;

	// Calibration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SENS_BASE:   coeff_q.c1 <= cfg.data;
				REG_OFFSET_BASE: coeff_q.c2 <= cfg.data;
				REG_SENS_TEMP:   coeff_q.c3 <= cfg.data;
				REG_OFFSET_TEMP: coeff_q.c4 <= cfg.data;
				REG_REF_TEMP:    coeff_q.c5 <= cfg.data;
				REG_TEMP_SLOPE:  coeff_q.c6 <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage valid bits and load enables.
	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.load      (load)
	);

	// First-order compensation.
	psc_first_order u_first (
		.clk             (clk),
		.load            (load[2:0]),
		.coeff           (coeff_q),
		.pressure_raw    (sample.pressure_raw),
		.temperature_raw (sample.temperature_raw),
		.first           (first)
	);

	// Second-order compensation.
	psc_second_order u_second (
		.clk    (clk),
		.load   (load[4:3]),
		.first  (first),
		.second (second)
	);

	// Pressure and depth.
	psc_pressure u_pressure (
		.clk                  (clk),
		.load                 (load[8:5]),
		.second               (second),
		.temperature_centideg (result.temperature_centideg),
		.pressure_centimbar   (result.pressure_centimbar),
		.depth_mm             (result.depth_mm)
	);

endmodule
